// ===== hw/rtl/spc_pkg.sv =====
`timescale 1ns / 1ps

package spc_pkg;

   localparam int NUM_SW             = 3;
   localparam int THRESH_W           = 16;
   localparam int DEFAULT_COUNT_BITS = 16;
   localparam int CSR_INDEX_W        = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUICK    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HELD     = 2'd3;

   localparam logic [THRESH_W-1:0] DEBOUNCE_RESET = 16'd5;
   localparam logic [THRESH_W-1:0] QUICK_RESET    = 16'd50;
   localparam logic [THRESH_W-1:0] LONG_RESET     = 16'd100;
   localparam logic [THRESH_W-1:0] HELD_RESET     = 16'd20;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_QUICK   = 3'd1,
      EV_LONG    = 3'd2,
      EV_HELD    = 3'd3,
      EV_RELEASE = 3'd4
   } event_type;

   typedef struct packed {
      logic [THRESH_W-1:0] debounce_ticks;
      logic [THRESH_W-1:0] quick_ticks;
      logic [THRESH_W-1:0] long_ticks;
      logic [THRESH_W-1:0] held_ticks;
   } spc_cfg_type;

   typedef struct packed {
      logic [2:0]        up_event;
      logic [2:0]        enter_event;
      logic [2:0]        down_event;
      logic [NUM_SW-1:0] cycle_done;
   } spc_rsp_type;

endpackage

// ===== hw/rtl/spc_if.sv =====
`timescale 1ns / 1ps

interface spc_req_if import spc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NUM_SW-1:0] edge_seen;
   logic [NUM_SW-1:0] level_pressed;

   modport source (output valid, output edge_seen, output level_pressed, input ready);
   modport sink   (input valid, input edge_seen, input level_pressed, output ready);
endinterface

interface spc_rsp_if import spc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        up_event;
   logic [2:0]        enter_event;
   logic [2:0]        down_event;
   logic [NUM_SW-1:0] cycle_done;

   modport source (output valid, output up_event, output enter_event, output down_event,
                   output cycle_done, input ready);
   modport sink   (input valid, input up_event, input enter_event, input down_event,
                   input cycle_done, output ready);
endinterface

// ===== hw/rtl/switch_press_classifier_top.sv =====
`timescale 1ns / 1ps

// switch press classifier: each request is one poll tick carrying press-edge flags and
// pressed levels for the up, enter and down switches (bits 0, 1, 2). every request gives
// exactly one response with a per-switch event (0 none, 1 quick, 2 long, 3 held,
// 4 release) and a cycle_done bit per switch. a response shows on rsp the cycle after
// its request unless rsp is stalled; a new request can be taken every cycle while
// req.ready is high. the response side has a two-entry buffer, so req.ready drops only
// when two responses wait. thresholds are in ticks and are written through the csr port
// (index 0 debounce, 1 quick, 2 long, 3 held); the user must write them only while the
// block is idle, not enforced by the block. the tick counters saturate at 2^COUNT_BITS-1.
module switch_press_classifier_top import spc_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   spc_req_if.sink                req,
   spc_rsp_if.source              rsp,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_wdata
);

   spc_cfg_type     cfg_ff;
   logic            accept;
   logic            can_push;
   event_type       sw_event [NUM_SW];
   logic [NUM_SW-1:0] sw_done;
   spc_rsp_type     result;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.quick_ticks    <= QUICK_RESET;
         cfg_ff.long_ticks     <= LONG_RESET;
         cfg_ff.held_ticks     <= HELD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            CSR_QUICK:    cfg_ff.quick_ticks    <= csr_wdata;
            CSR_LONG:     cfg_ff.long_ticks     <= csr_wdata;
            CSR_HELD:     cfg_ff.held_ticks     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // a request advances all three switch machines together
   assign req.ready = can_push;
   assign accept    = req.valid && can_push;

   for (genvar s = 0; s < NUM_SW; s++) begin : g_sw
      spc_switch_fsm #(
         .COUNT_BITS (COUNT_BITS)
      ) u_fsm (
         .clock    (clock),
         .reset    (reset),
         .advance  (accept),
         .edge_bit (req.edge_seen[s]),
         .pressed  (req.level_pressed[s]),
         .cfg      (cfg_ff),
         .ev       (sw_event[s]),
         .done     (sw_done[s])
      );
   end

   // pack the per-switch results into one response
   always_comb begin
      result.up_event    = sw_event[0];
      result.enter_event = sw_event[1];
      result.down_event  = sw_event[2];
      result.cycle_done  = sw_done;
   end

   // response register with skid entry
   spc_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .can_push  (can_push),
      .rsp       (rsp)
   );

endmodule

// ===== hw/rtl/spc_switch_fsm.sv =====
`timescale 1ns / 1ps

module spc_switch_fsm import spc_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        edge_bit,
   input  logic        pressed,
   input  spc_cfg_type cfg,
   output event_type   ev,
   output logic        done
);

   localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_DEB_PRESS   = 3'd1,
      PH_QUICK       = 3'd2,
      PH_LONG        = 3'd3,
      PH_HELD        = 3'd4,
      PH_DEB_RELEASE = 3'd5
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  pending_ff, pending_in;

   logic [COUNT_BITS-1:0] bumped;
   logic [CMP_W-1:0]      bumped_x, deb_x, quick_x, long_x, held_x;
   logic                  pend;

   // saturating increment
   assign bumped   = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign bumped_x = CMP_W'(bumped);
   assign deb_x    = CMP_W'(cfg.debounce_ticks);
   assign quick_x  = CMP_W'(cfg.quick_ticks);
   assign long_x   = CMP_W'(cfg.long_ticks);
   assign held_x   = CMP_W'(cfg.held_ticks);
   assign pend     = pending_ff | edge_bit;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      pending_in = pend;
      ev         = EV_NONE;
      done       = 1'b0;
      case (phase_ff)
         PH_DEB_PRESS: begin
            count_in = bumped;
            if (bumped_x > deb_x) begin
               count_in = '0;
               phase_in = PH_QUICK;
            end
         end
         PH_QUICK: begin
            count_in = bumped;
            if (!pressed) begin
               ev       = EV_QUICK;
               count_in = '0;
               phase_in = PH_DEB_RELEASE;
            end else if (bumped_x >= quick_x) begin
               count_in = '0;
               phase_in = PH_LONG;
            end
         end
         PH_LONG: begin
            count_in = bumped;
            if (!pressed) begin
               ev       = EV_QUICK;
               count_in = '0;
               phase_in = PH_DEB_RELEASE;
            end else if (bumped_x >= long_x) begin
               ev       = EV_LONG;
               count_in = '0;
               phase_in = PH_HELD;
            end
         end
         PH_HELD: begin
            count_in = bumped;
            if (!pressed) begin
               count_in = '0;
               phase_in = PH_DEB_RELEASE;
            end else if (bumped_x >= held_x) begin
               ev       = EV_HELD;
               count_in = '0;
            end
         end
         PH_DEB_RELEASE: begin
            count_in = bumped;
            if (bumped_x > deb_x) begin
               ev         = EV_RELEASE;
               count_in   = '0;
               phase_in   = PH_IDLE;
               done       = 1'b1;
               pending_in = 1'b0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (pend) begin
               count_in = '0;
               phase_in = PH_DEB_PRESS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> !pending_ff && phase_ff == PH_IDLE && count_ff == '0)
      else $error("finished cycle left pending or phase set");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(count_ff) && $stable(pending_ff))
      else $error("switch state moved without a request");

   a_pending_in_cycle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> pending_ff)
      else $error("press cycle running with pending clear");

endmodule

// ===== hw/rtl/spc_out_buf.sv =====
`timescale 1ns / 1ps

module spc_out_buf import spc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  spc_rsp_type push_data,
   output logic        can_push,
   spc_rsp_if.source   rsp
);

   logic        out_valid_ff, out_valid_in;
   spc_rsp_type out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   spc_rsp_type skid_ff, skid_in;
   logic        out_free;

   assign can_push = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.up_event    = out_ff.up_event;
   assign rsp.enter_event = out_ff.enter_event;
   assign rsp.down_event  = out_ff.down_event;
   assign rsp.cycle_done  = out_ff.cycle_done;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp.ready |=> out_valid_ff && out_ff == $past(skid_ff))
      else $error("skid entry lost or reordered");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed into a full buffer");

endmodule
